[rtl/core/pbb_pkg.sv]
package pbb_pkg;

    localparam int MAX_CELLS_DEF = 16;
    localparam int FILL_BITS_DEF = 16;

    localparam int COORD_W     = 32;
    localparam int EDGE_W      = 32;
    localparam int CELLS_CFG_W = 5;
    localparam int QUANT_W     = 8;
    localparam int INDEX_W     = 12;
    localparam int SLOT_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int STEP_W      = 4;
    localparam int AXIS_W      = 2;

    localparam logic [QUANT_W-1:0] LOCAL_MAX = 8'hFF;
    localparam logic [AXIS_W-1:0]  AXIS_LAST = 2'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_ORIGIN_Z   = 3'd2,
        CFG_BRICK_EDGE = 3'd3,
        CFG_CELLS_X    = 3'd4,
        CFG_CELLS_Y    = 3'd5,
        CFG_CELLS_Z    = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_RANGE,
        ST_CDIV,
        ST_QDIV,
        ST_IDX1,
        ST_IDX2,
        ST_READ,
        ST_WRITE
    } st_t;

    // Command to the shared divider: the partial remainder to start from, the
    // dividend bits still to be shifted in (MSB first) and the step count.
    typedef struct packed {
        logic                start;
        logic [EDGE_W-1:0]   rem_init;
        logic [QUANT_W-1:0]  low_init;
        logic [STEP_W-1:0]   steps;
    } div_cmd_t;

    typedef struct packed {
        logic                done;
        logic [QUANT_W-1:0]  quotient;
        logic [EDGE_W-1:0]   remainder;
    } div_res_t;

endpackage

[rtl/core/pbb_divider.sv]
module pbb_divider
    import pbb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  div_cmd_t          cmd,
    input  logic [EDGE_W-1:0] divisor,
    output div_res_t          res
);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   cnt_reg;
    logic [EDGE_W-1:0]   rem_reg;
    logic [QUANT_W-1:0]  low_reg;
    logic [QUANT_W-1:0]  quo_reg;

    logic [EDGE_W:0]     trial;
    logic [EDGE_W:0]     trial_sub;
    logic                fits;
    logic [EDGE_W-1:0]   rem_step;

    // One restoring step. The partial remainder stays below the divisor, so
    // the difference always fits back into the remainder register.
    assign trial     = {rem_reg, low_reg[QUANT_W-1]};
    assign fits      = trial >= {1'b0, divisor};
    assign trial_sub = trial - {1'b0, divisor};
    assign rem_step  = fits ? trial_sub[EDGE_W-1:0] : trial[EDGE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= cmd.steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= cmd.rem_init;
            low_reg <= cmd.low_init;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            low_reg <= {low_reg[QUANT_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUANT_W-2:0], fits};
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

    a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy_reg)
        else $error("divider started while a division is in progress");

endmodule

[rtl/core/pbb_fill_store.sv]
module pbb_fill_store
    import pbb_pkg::*;
#(
    parameter int DEPTH     = MAX_CELLS_DEF * MAX_CELLS_DEF * MAX_CELLS_DEF,
    parameter int ADDR_W    = $clog2(MAX_CELLS_DEF * MAX_CELLS_DEF * MAX_CELLS_DEF),
    parameter int FILL_BITS = FILL_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear_start,
    output logic                 clearing,
    input  logic                 rd_en,
    input  logic [ADDR_W-1:0]    rd_addr,
    output logic [FILL_BITS-1:0] rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  logic [FILL_BITS-1:0] wr_data
);

    logic [FILL_BITS-1:0] mem [0:DEPTH-1];
    logic [FILL_BITS-1:0] rd_data_reg;
    logic                 clearing_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;

    // The sweep runs once after reset and again on every clear request,
    // zeroing one counter per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clear_start)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign clearing = clearing_reg;
    assign rd_data  = rd_data_reg;

endmodule

[rtl/core/point_brick_binner.sv]
// Here CB = $clog2(MAX_CELLS_PER_AXIS + 1), with a default of 16 cells per axis.
// An axis in range runs CB cell steps and, when its cell lies inside the grid,
// 8 quantizing steps on the one shared divider.
// One point at a time; the next beat follows the result.
// After reset, and after every clear beat, a sweep over the MAX_CELLS_PER_AXIS^3
// fill counters (4096 by default) zeroes them; no point is accepted meanwhile.
module point_brick_binner
    import pbb_pkg::*;
#(
    parameter int MAX_CELLS_PER_AXIS = MAX_CELLS_DEF,
    parameter int FILL_BITS          = FILL_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [EDGE_W-1:0]         cfg_data,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      mode,
    input  logic signed [COORD_W-1:0] point_x,
    input  logic signed [COORD_W-1:0] point_y,
    input  logic signed [COORD_W-1:0] point_z,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [INDEX_W-1:0]        brick_index,
    output logic [SLOT_W-1:0]         slot,
    output logic [QUANT_W-1:0]        local_x,
    output logic [QUANT_W-1:0]        local_y,
    output logic [QUANT_W-1:0]        local_z,
    output logic                      first_in_brick,
    output logic                      out_of_range,
    output logic                      slot_saturated
);

    localparam int CB     = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam int P_W    = 2 * CB;
    localparam int S_W    = 3 * CB;
    localparam int DEPTH  = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SPAN_W = COORD_W + 1 + QUANT_W;

    // Configuration registers.
    logic signed [COORD_W-1:0] origin_reg [0:2];
    logic [EDGE_W-1:0]         edge_cfg_reg;
    logic [CELLS_CFG_W-1:0]    cells_cfg_reg [0:2];

    // Per-point working registers.
    st_t                       state_reg, state_next;
    logic [AXIS_W-1:0]         axis_reg, axis_next;
    logic signed [COORD_W:0]   d_reg, d_next;
    logic [CB-1:0]             cell_reg [0:2];
    logic [CB-1:0]             cell_next [0:2];
    logic [QUANT_W-1:0]        local_reg [0:2];
    logic [QUANT_W-1:0]        local_next [0:2];
    logic                      oor_reg, oor_next;
    logic [P_W-1:0]            part_reg, part_next;
    logic [P_W-1:0]            cxy_reg, cxy_next;
    logic [ADDR_W-1:0]         idx_reg, idx_next;
    logic signed [COORD_W-1:0] pt_reg [0:2];
    logic [EDGE_W-1:0]         edge_reg;
    logic [CB-1:0]             cells_reg [0:2];

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]        idx_out_reg;
    logic [SLOT_W-1:0]         slot_out_reg;
    logic [QUANT_W-1:0]        lx_out_reg, ly_out_reg, lz_out_reg;
    logic                      first_out_reg, oor_out_reg, sat_out_reg;
    logic                      out_load;

    // Datapath signals.
    div_cmd_t                  div_cmd;
    div_res_t                  div_res;
    logic                      clearing;
    logic                      clear_start;
    logic                      rd_en;
    logic                      wr_en;
    logic [FILL_BITS-1:0]      rd_data;
    logic [FILL_BITS-1:0]      wr_data;
    logic                      fill_sat;
    logic                      accept;

    logic signed [COORD_W-1:0] pt_sel;
    logic signed [COORD_W-1:0] org_sel;
    logic [CB-1:0]             cells_sel;
    logic signed [COORD_W:0]   d_calc;
    logic [COORD_W:0]          d_u;
    logic [SPAN_W-1:0]         span;
    logic                      beyond;
    logic [CB-1:0]             q_cell;
    logic                      q_clamp;
    logic                      q_exact;
    logic [EDGE_W+QUANT_W-1:0] qprod;

    function automatic logic [CB-1:0] eff_cells(input logic [CELLS_CFG_W-1:0] c);
        if (c == '0)
            return CB'(1);
        else if (int'(c) > MAX_CELLS_PER_AXIS)
            return CB'(MAX_CELLS_PER_AXIS);
        else
            return CB'(c);
    endfunction

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && !clearing;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0]    <= '0;
            origin_reg[1]    <= '0;
            origin_reg[2]    <= '0;
            edge_cfg_reg     <= EDGE_W'(65536);
            cells_cfg_reg[0] <= CELLS_CFG_W'(16);
            cells_cfg_reg[1] <= CELLS_CFG_W'(16);
            cells_cfg_reg[2] <= CELLS_CFG_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X:   origin_reg[0]    <= cfg_data;
                CFG_ORIGIN_Y:   origin_reg[1]    <= cfg_data;
                CFG_ORIGIN_Z:   origin_reg[2]    <= cfg_data;
                CFG_BRICK_EDGE: edge_cfg_reg     <= cfg_data;
                CFG_CELLS_X:    cells_cfg_reg[0] <= cfg_data[CELLS_CFG_W-1:0];
                CFG_CELLS_Y:    cells_cfg_reg[1] <= cfg_data[CELLS_CFG_W-1:0];
                CFG_CELLS_Z:    cells_cfg_reg[2] <= cfg_data[CELLS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    pbb_divider u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (div_cmd),
        .divisor (edge_reg),
        .res     (div_res)
    );

    pbb_fill_store #(
        .DEPTH     (DEPTH),
        .ADDR_W    (ADDR_W),
        .FILL_BITS (FILL_BITS)
    ) u_fill (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear_start (clear_start),
        .clearing    (clearing),
        .rd_en       (rd_en),
        .rd_addr     (idx_reg),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (idx_reg),
        .wr_data     (wr_data)
    );

    always_comb
    begin
        unique case (axis_reg)
            2'd0:
            begin
                pt_sel    = pt_reg[0];
                org_sel   = origin_reg[0];
                cells_sel = cells_reg[0];
            end
            2'd1:
            begin
                pt_sel    = pt_reg[1];
                org_sel   = origin_reg[1];
                cells_sel = cells_reg[1];
            end
            default:
            begin
                pt_sel    = pt_reg[2];
                org_sel   = origin_reg[2];
                cells_sel = cells_reg[2];
            end
        endcase
    end

    assign d_calc = {pt_sel[COORD_W-1], pt_sel} - {org_sel[COORD_W-1], org_sel};
    assign d_u    = d_reg;

    // An offset at or past 2^CB bricks is out of the grid whatever the
    // configured cell count, so the cell division only needs CB quotient bits.
    assign span   = SPAN_W'(edge_reg) << CB;
    assign beyond = SPAN_W'(d_u) >= span;

    assign q_cell  = div_res.quotient[CB-1:0];
    assign q_clamp = q_cell >= cells_sel;
    assign q_exact = (q_cell == cells_sel) && (div_res.remainder == '0);

    // remainder * 255; the quotient by the edge is below 256.
    assign qprod = {div_res.remainder, {QUANT_W{1'b0}}}
                 - {{QUANT_W{1'b0}}, div_res.remainder};

    assign fill_sat = &rd_data;
    assign wr_data  = rd_data + 1'b1;
    assign out_load = (state_reg == ST_WRITE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        d_next         = d_reg;
        cell_next      = cell_reg;
        local_next     = local_reg;
        oor_next       = oor_reg;
        part_next      = part_reg;
        cxy_next       = cxy_reg;
        idx_next       = idx_reg;
        div_cmd        = '0;
        clear_start    = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode)
                    begin
                        clear_start = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_DIFF;
                        axis_next  = '0;
                        oor_next   = 1'b0;
                    end
                end
            end
            ST_DIFF:
            begin
                d_next     = d_calc;
                state_next = ST_RANGE;
            end
            ST_RANGE:
            begin
                if (d_reg[COORD_W])
                begin
                    cell_next[axis_reg]  = '0;
                    local_next[axis_reg] = '0;
                    oor_next             = 1'b1;
                    axis_next            = axis_reg + 1'b1;
                    state_next           = (axis_reg == AXIS_LAST) ? ST_IDX1 : ST_DIFF;
                end
                else if (beyond)
                begin
                    cell_next[axis_reg]  = cells_sel - 1'b1;
                    local_next[axis_reg] = LOCAL_MAX;
                    oor_next             = 1'b1;
                    axis_next            = axis_reg + 1'b1;
                    state_next           = (axis_reg == AXIS_LAST) ? ST_IDX1 : ST_DIFF;
                end
                else
                begin
                    div_cmd.start    = 1'b1;
                    div_cmd.rem_init = EDGE_W'(d_u >> CB);
                    div_cmd.low_init = {d_u[CB-1:0], {(QUANT_W - CB){1'b0}}};
                    div_cmd.steps    = STEP_W'(CB);
                    state_next       = ST_CDIV;
                end
            end
            ST_CDIV:
            begin
                if (div_res.done)
                begin
                    if (q_clamp)
                    begin
                        // Past the last cell the local offset is a full edge or more.
                        cell_next[axis_reg]  = cells_sel - 1'b1;
                        local_next[axis_reg] = LOCAL_MAX;
                        if (!q_exact)
                        begin
                            oor_next = 1'b1;
                        end
                        axis_next  = axis_reg + 1'b1;
                        state_next = (axis_reg == AXIS_LAST) ? ST_IDX1 : ST_DIFF;
                    end
                    else
                    begin
                        cell_next[axis_reg] = q_cell;
                        div_cmd.start       = 1'b1;
                        div_cmd.rem_init    = qprod[EDGE_W+QUANT_W-1:QUANT_W];
                        div_cmd.low_init    = qprod[QUANT_W-1:0];
                        div_cmd.steps       = STEP_W'(QUANT_W);
                        state_next          = ST_QDIV;
                    end
                end
            end
            ST_QDIV:
            begin
                if (div_res.done)
                begin
                    local_next[axis_reg] = div_res.quotient;
                    axis_next            = axis_reg + 1'b1;
                    state_next           = (axis_reg == AXIS_LAST) ? ST_IDX1 : ST_DIFF;
                end
            end
            ST_IDX1:
            begin
                part_next  = P_W'(cell_reg[1]) * P_W'(cells_reg[0]) + P_W'(cell_reg[0]);
                cxy_next   = P_W'(cells_reg[0]) * P_W'(cells_reg[1]);
                state_next = ST_IDX2;
            end
            ST_IDX2:
            begin
                idx_next   = ADDR_W'(S_W'(cell_reg[2]) * S_W'(cxy_reg) + S_W'(part_reg));
                state_next = ST_READ;
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_load)
                begin
                    wr_en          = !fill_sat;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            oor_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            oor_reg       <= oor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        cell_reg  <= cell_next;
        local_reg <= local_next;
        part_reg  <= part_next;
        cxy_reg   <= cxy_next;
        idx_reg   <= idx_next;
        if (accept)
        begin
            pt_reg[0]    <= point_x;
            pt_reg[1]    <= point_y;
            pt_reg[2]    <= point_z;
            edge_reg     <= (edge_cfg_reg == '0) ? EDGE_W'(1) : edge_cfg_reg;
            cells_reg[0] <= eff_cells(cells_cfg_reg[0]);
            cells_reg[1] <= eff_cells(cells_cfg_reg[1]);
            cells_reg[2] <= eff_cells(cells_cfg_reg[2]);
        end
        if (out_load)
        begin
            idx_out_reg   <= INDEX_W'(idx_reg);
            slot_out_reg  <= SLOT_W'(rd_data);
            lx_out_reg    <= local_reg[0];
            ly_out_reg    <= local_reg[1];
            lz_out_reg    <= local_reg[2];
            first_out_reg <= (rd_data == '0);
            oor_out_reg   <= oor_reg;
            sat_out_reg   <= fill_sat;
        end
    end

    assign out_valid      = out_valid_reg;
    assign brick_index    = idx_out_reg;
    assign slot           = slot_out_reg;
    assign local_x        = lx_out_reg;
    assign local_y        = ly_out_reg;
    assign local_z        = lz_out_reg;
    assign first_in_brick = first_out_reg;
    assign out_of_range   = oor_out_reg;
    assign slot_saturated = sat_out_reg;

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && mode) |=> !in_ready)
        else $error("input taken right after a clear beat");

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WRITE))
        else $error("result appeared outside the write step");

    a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !clearing)
        else $error("fill counter update during the clearing sweep");

    a_sat_not_first: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && slot_saturated) |-> !first_in_brick)
        else $error("saturated counter reported as first in brick");

endmodule
